>>> rtl/core/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB conversion package
// Shared widths, constants and sector codes for the HSV to RGB datapath.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   // Fixed-point format of hue, saturation and value.
   localparam int FRAC_BITS = 16;

   // Field widths.
   localparam int HUE_W   = FRAC_BITS;          // Q0.F hue
   localparam int SV_W    = FRAC_BITS + 1;      // Q1.F saturation and value
   localparam int H6_W    = FRAC_BITS + 3;      // hue times six
   localparam int SECT_W  = 3;                  // sector number 0..5
   localparam int W_W     = FRAC_BITS + 1;      // sector weight, up to 1.0
   localparam int C_W     = 2 * FRAC_BITS + 1;  // chroma and channel sums, Q1.2F
   localparam int XP_W    = C_W + W_W;          // chroma times weight
   localparam int BYTE_W  = 8;

   // Unity in Q1.F.
   localparam logic [SV_W-1:0] ONE_FX = SV_W'(1) << FRAC_BITS;

   // Byte scaling: floor(sum * 25599 / 100 / 2^(2F)).
   localparam int SCALE_W  = 15;
   localparam logic [SCALE_W-1:0] SCALE_NUM = SCALE_W'(25599);
   localparam int SP_W     = C_W + SCALE_W;     // scaled product
   localparam int T_W      = 15;                // scaled sum before the divide by 100
   localparam logic [T_W-1:0] T_MAX = T_W'(25599);

   // Divide by 100 through a reciprocal, exact for every value up to T_MAX.
   localparam int RECIP_W     = 13;
   localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
   localparam int RECIP_SHIFT = 19;
   localparam int RP_W        = T_W + RECIP_W;
   localparam int Q_W         = BYTE_W + 1;
   localparam logic [Q_W-1:0] BYTE_MAX = Q_W'(255);

   // Hue sectors, sixty degrees each.
   localparam logic [SECT_W-1:0] SECT_RED_YELLOW    = 3'd0;
   localparam logic [SECT_W-1:0] SECT_YELLOW_GREEN  = 3'd1;
   localparam logic [SECT_W-1:0] SECT_GREEN_CYAN    = 3'd2;
   localparam logic [SECT_W-1:0] SECT_CYAN_BLUE     = 3'd3;
   localparam logic [SECT_W-1:0] SECT_BLUE_MAGENTA  = 3'd4;
   localparam logic [SECT_W-1:0] SECT_MAGENTA_RED   = 3'd5;

   // Number of register stages in the datapath.
   localparam int NUM_STAGES = 6;

endpackage

>>> rtl/core/hsv2rgb_ifs.sv
// ----------------------------------------------------------------------------
// HSV to RGB stream interfaces
// Valid/ready channels for HSV requests and RGB responses.
// ----------------------------------------------------------------------------

// Request channel: one HSV pixel per request.
interface hsv2rgb_req_if import hsv2rgb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [SV_W-1:0]   saturation;
   logic [SV_W-1:0]   brightness;
   logic              hue_undefined;

   modport source (output valid, output hue, output saturation, output brightness,
                   output hue_undefined, input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   input hue_undefined, output ready);
endinterface

// Response channel: one RGB pixel per response.
interface hsv2rgb_rsp_if import hsv2rgb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] red;
   logic [BYTE_W-1:0] green;
   logic [BYTE_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/core/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Six-stage pipeline turning one HSV pixel into 8-bit red, green and blue.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_bus   in         valid / ready        hue, saturation, brightness,
//                                             hue_undefined
//   rsp_bus   out        valid / ready        red, green, blue
//
// A request accepted on req_bus loads the first of six register stages (sector
// split, s*v multiply, chroma weighting, sector mux and offset add, byte
// scaling, divide by 100 and output register). Its response becomes valid
// once it reaches the output register and is taken when rsp_bus is ready.
// One request enters per cycle while the response side keeps up.
// Each stage holds its data while the stage after it is full and stalled, and
// an empty stage accepts new data even when the output is blocked.
// Reset clears every stage valid bit; the datapath registers are not reset.
//
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   hsv2rgb_req_if.sink          req_bus,
   hsv2rgb_rsp_if.source        rsp_bus
);

   // Pipeline control: one valid bit per stage and a load enable per stage.
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] stage_en;

   // A stage may load when it is empty or the stage after it moves on.
   always_comb begin
      stage_en[NUM_STAGES-1] = ~vld_ff[NUM_STAGES-1] | rsp_bus.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = ~vld_ff[k] | stage_en[k+1];
      end
      vld_in = {vld_ff[NUM_STAGES-2:0], req_bus.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_bus.ready = stage_en[0];

   // ------------------------------------------------------------------
   // Stage 1: clamp saturation and value, split the hue into a sector and
   // the weight of the second component.
   // ------------------------------------------------------------------
   logic [H6_W-1:0]      h6;
   logic [FRAC_BITS-1:0] hue_frac;
   logic [SECT_W-1:0]    sect1_in;
   logic [W_W-1:0]       w1_in;
   logic [SV_W-1:0]      s1_in;
   logic [SV_W-1:0]      v1_in;

   logic [SECT_W-1:0]    sect1_ff;
   logic [W_W-1:0]       w1_ff;
   logic [SV_W-1:0]      s1_ff;
   logic [SV_W-1:0]      v1_ff;
   logic                 undef1_ff;

   always_comb begin
      h6       = (H6_W'(req_bus.hue) << 2) + (H6_W'(req_bus.hue) << 1);
      sect1_in = h6[H6_W-1:FRAC_BITS];
      hue_frac = h6[FRAC_BITS-1:0];
      // Odd sectors fall toward the next primary, even sectors rise.
      w1_in    = sect1_in[0] ? (W_W'(ONE_FX) - W_W'(hue_frac)) : W_W'(hue_frac);
      s1_in    = (req_bus.saturation > ONE_FX) ? ONE_FX : req_bus.saturation;
      v1_in    = (req_bus.brightness > ONE_FX) ? ONE_FX : req_bus.brightness;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sect1_ff  <= sect1_in;
         w1_ff     <= w1_in;
         s1_ff     <= s1_in;
         v1_ff     <= v1_in;
         undef1_ff <= req_bus.hue_undefined;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: chroma is saturation times value.
   // ------------------------------------------------------------------
   logic [C_W-1:0]    c2_in;
   logic [C_W-1:0]    c2_ff;
   logic [SECT_W-1:0] sect2_ff;
   logic [W_W-1:0]    w2_ff;
   logic [SV_W-1:0]   v2_ff;
   logic              undef2_ff;

   assign c2_in = C_W'(s1_ff) * C_W'(v1_ff);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         c2_ff     <= c2_in;
         sect2_ff  <= sect1_ff;
         w2_ff     <= w1_ff;
         v2_ff     <= v1_ff;
         undef2_ff <= undef1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: second component and the offset added to every channel.
   // ------------------------------------------------------------------
   logic [XP_W-1:0]   xprod;
   logic [C_W-1:0]    x3_in;
   logic [C_W-1:0]    m3_in;
   logic [C_W-1:0]    c3_ff;
   logic [C_W-1:0]    x3_ff;
   logic [C_W-1:0]    m3_ff;
   logic [SECT_W-1:0] sect3_ff;
   logic              undef3_ff;

   always_comb begin
      xprod = XP_W'(c2_ff) * XP_W'(w2_ff);
      x3_in = xprod[FRAC_BITS +: C_W];
      m3_in = (C_W'(v2_ff) << FRAC_BITS) - c2_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         c3_ff     <= c2_ff;
         x3_ff     <= x3_in;
         m3_ff     <= m3_in;
         sect3_ff  <= sect2_ff;
         undef3_ff <= undef2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: route chroma and the second component by sector, add offset.
   // ------------------------------------------------------------------
   logic [C_W-1:0] r_comp;
   logic [C_W-1:0] g_comp;
   logic [C_W-1:0] b_comp;
   logic [C_W-1:0] r4_ff;
   logic [C_W-1:0] g4_ff;
   logic [C_W-1:0] b4_ff;
   logic           undef4_ff;

   always_comb begin
      unique case (sect3_ff)
         SECT_RED_YELLOW: begin
            r_comp = c3_ff; g_comp = x3_ff; b_comp = '0;
         end
         SECT_YELLOW_GREEN: begin
            r_comp = x3_ff; g_comp = c3_ff; b_comp = '0;
         end
         SECT_GREEN_CYAN: begin
            r_comp = '0;    g_comp = c3_ff; b_comp = x3_ff;
         end
         SECT_CYAN_BLUE: begin
            r_comp = '0;    g_comp = x3_ff; b_comp = c3_ff;
         end
         SECT_BLUE_MAGENTA: begin
            r_comp = x3_ff; g_comp = '0;    b_comp = c3_ff;
         end
         default: begin
            r_comp = c3_ff; g_comp = '0;    b_comp = x3_ff;
         end
      endcase
   end

   // The sums never pass value times unity, so they fit the chroma width.
   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         r4_ff     <= r_comp + m3_ff;
         g4_ff     <= g_comp + m3_ff;
         b4_ff     <= b_comp + m3_ff;
         undef4_ff <= undef3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: scale each channel by 25599 and keep the integer part.
   // ------------------------------------------------------------------
   logic [SP_W-1:0] r_scaled;
   logic [SP_W-1:0] g_scaled;
   logic [SP_W-1:0] b_scaled;
   logic [T_W-1:0]  r5_ff;
   logic [T_W-1:0]  g5_ff;
   logic [T_W-1:0]  b5_ff;
   logic            undef5_ff;

   always_comb begin
      r_scaled = SP_W'(r4_ff) * SP_W'(SCALE_NUM);
      g_scaled = SP_W'(g4_ff) * SP_W'(SCALE_NUM);
      b_scaled = SP_W'(b4_ff) * SP_W'(SCALE_NUM);
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         r5_ff     <= r_scaled[2*FRAC_BITS +: T_W];
         g5_ff     <= g_scaled[2*FRAC_BITS +: T_W];
         b5_ff     <= b_scaled[2*FRAC_BITS +: T_W];
         undef5_ff <= undef4_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: divide by 100, saturate, and force black for undefined hue.
   // ------------------------------------------------------------------
   logic [RP_W-1:0]   r_recip;
   logic [RP_W-1:0]   g_recip;
   logic [RP_W-1:0]   b_recip;
   logic [Q_W-1:0]    r_quot;
   logic [Q_W-1:0]    g_quot;
   logic [Q_W-1:0]    b_quot;
   logic [BYTE_W-1:0] red_in;
   logic [BYTE_W-1:0] green_in;
   logic [BYTE_W-1:0] blue_in;
   logic [BYTE_W-1:0] red_ff;
   logic [BYTE_W-1:0] green_ff;
   logic [BYTE_W-1:0] blue_ff;

   always_comb begin
      r_recip = RP_W'(r5_ff) * RP_W'(RECIP_100);
      g_recip = RP_W'(g5_ff) * RP_W'(RECIP_100);
      b_recip = RP_W'(b5_ff) * RP_W'(RECIP_100);
      r_quot  = r_recip[RECIP_SHIFT +: Q_W];
      g_quot  = g_recip[RECIP_SHIFT +: Q_W];
      b_quot  = b_recip[RECIP_SHIFT +: Q_W];
      red_in   = (r_quot > BYTE_MAX) ? BYTE_MAX[BYTE_W-1:0] : r_quot[BYTE_W-1:0];
      green_in = (g_quot > BYTE_MAX) ? BYTE_MAX[BYTE_W-1:0] : g_quot[BYTE_W-1:0];
      blue_in  = (b_quot > BYTE_MAX) ? BYTE_MAX[BYTE_W-1:0] : b_quot[BYTE_W-1:0];
      if (undef5_ff) begin
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_bus.valid = vld_ff[NUM_STAGES-1];
   assign rsp_bus.red   = red_ff;
   assign rsp_bus.green = green_ff;
   assign rsp_bus.blue  = blue_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------

   // Chroma never exceeds the value it was taken from.
   a_chroma_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] |-> (c2_ff <= (C_W'(v2_ff) << FRAC_BITS)))
      else $error("chroma exceeds value");

   // A full stage that cannot move keeps its data for the next cycle.
   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[2] && !stage_en[3]) |=> (vld_ff[2] && $stable(x3_ff) && $stable(m3_ff)))
      else $error("stalled stage lost its data");

   // Channel sums stay within unity in Q1.2F.
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> ((r4_ff <= (C_W'(1) << (2*FRAC_BITS))) &&
                     (g4_ff <= (C_W'(1) << (2*FRAC_BITS))) &&
                     (b4_ff <= (C_W'(1) << (2*FRAC_BITS)))))
      else $error("channel sum out of range");

   // The scaled channels stay in the range where the reciprocal is exact.
   a_scaled_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> ((r5_ff <= T_MAX) && (g5_ff <= T_MAX) && (b5_ff <= T_MAX)))
      else $error("scaled channel out of range");

endmodule

>>> tb/hsv2rgb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB response checker
// Watches the request and response channels, works out the expected red,
// green and blue for every accepted request and compares each accepted
// response against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module hsv2rgb_checker import hsv2rgb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   hsv2rgb_req_if       req_mon,
   hsv2rgb_rsp_if       rsp_mon,
   output int unsigned  fail_count,
   output int unsigned  pending
);

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } rgb_pixel_type;

   // Expected pixels in request order.
   rgb_pixel_type rgb_queue[$];
   rgb_pixel_type want_px;
   int unsigned   mismatches = 0;

   // Saturate a Q1.F level at 1.0.
   function automatic logic [63:0] clamp_unit(input logic [SV_W-1:0] level);
      return (level > ONE_FX) ? 64'(ONE_FX) : 64'(level);
   endfunction

   // Scale a Q1.2F channel sum by 255.99, truncate and saturate at 255.
   function automatic logic [BYTE_W-1:0] scale_to_byte(input logic [63:0] level);
      logic [63:0] q;
      q = ((level * 64'd25599) / 64'd100) >> (2 * FRAC_BITS);
      return (q > 64'd255) ? 8'd255 : q[BYTE_W-1:0];
   endfunction

   // Expected color for one HSV pixel.
   function automatic rgb_pixel_type hsv_pixel_to_rgb(input logic [HUE_W-1:0] hue,
                                                     input logic [SV_W-1:0]  sat,
                                                     input logic [SV_W-1:0]  val,
                                                     input logic             undef);
      logic [63:0]       s, v, h6, f, w, chroma, second, offset, r, g, b;
      logic [SECT_W-1:0] sector;
      rgb_pixel_type     px;
      if (undef) begin
         return '0;
      end
      s      = clamp_unit(sat);
      v      = clamp_unit(val);
      h6     = 64'(hue) * 64'd6;
      sector = h6[FRAC_BITS+2:FRAC_BITS];
      f      = h6 & ((64'd1 << FRAC_BITS) - 64'd1);
      // The weight rises through even sectors and falls through odd ones.
      w      = sector[0] ? ((64'd1 << FRAC_BITS) - f) : f;
      chroma = s * v;
      second = (chroma * w) >> FRAC_BITS;
      offset = (v << FRAC_BITS) - chroma;
      case (sector)
         SECT_RED_YELLOW: begin
            r = chroma; g = second; b = '0;
         end
         SECT_YELLOW_GREEN: begin
            r = second; g = chroma; b = '0;
         end
         SECT_GREEN_CYAN: begin
            r = '0; g = chroma; b = second;
         end
         SECT_CYAN_BLUE: begin
            r = '0; g = second; b = chroma;
         end
         SECT_BLUE_MAGENTA: begin
            r = second; g = '0; b = chroma;
         end
         default: begin
            r = chroma; g = '0; b = second;
         end
      endcase
      px.red   = scale_to_byte(r + offset);
      px.green = scale_to_byte(g + offset);
      px.blue  = scale_to_byte(b + offset);
      return px;
   endfunction

   task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                              input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Responses are matched before new requests are queued, so a response
   // always pairs with a request accepted at an earlier edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (rgb_queue.size() == 0) begin
               $error("unexpected response: red %0d, green %0d, blue %0d",
                      rsp_mon.red, rsp_mon.green, rsp_mon.blue);
               mismatches++;
            end else begin
               want_px = rgb_queue.pop_front();
               check_field("red", want_px.red, rsp_mon.red);
               check_field("green", want_px.green, rsp_mon.green);
               check_field("blue", want_px.blue, rsp_mon.blue);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            rgb_queue.push_back(hsv_pixel_to_rgb(req_mon.hue, req_mon.saturation,
                                                 req_mon.brightness,
                                                 req_mon.hue_undefined));
         end
      end
      pending    <= rgb_queue.size();
      fail_count <= mismatches;
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives directed corner pixels and then random pixels into the converter,
// with random idle cycles on both channels, and reports the verdict from the
// checker's mismatch count.
// ----------------------------------------------------------------------------
module tb;
   import hsv2rgb_pkg::*;

   localparam int RANDOM_PIXELS = 400;
   localparam int STALL_LIMIT   = 5000;
   localparam int IDLE_PERCENT  = 34;

   logic        clock;
   logic        reset;
   logic        gaps_on;
   int unsigned fail_count;
   int unsigned pending;

   hsv2rgb_req_if req_bus ();
   hsv2rgb_rsp_if rsp_bus ();

   hsv_to_rgb_converter dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   hsv2rgb_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 100 MHz clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: random back-pressure while gaps are enabled.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= gaps_on ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   initial begin
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= STALL_LIMIT) begin
            $display("** hsv_to_rgb_converter: FAILED **");
            $finish;
         end
      end
   end

   // Random level in Q1.F, with extra weight on zero, one and values above one.
   function automatic logic [SV_W-1:0] random_level();
      case ($urandom_range(9))
         0:       return '0;
         1:       return ONE_FX;
         2:       return SV_W'($urandom_range(131071, 65537));
         default: return SV_W'($urandom_range(65536));
      endcase
   endfunction

   // Present one request, with optional idle cycles first, and hold it until
   // it is accepted. Valid stays high on return.
   task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [SV_W-1:0] sat,
                             input logic [SV_W-1:0] val, input logic undef);
      while (gaps_on && ($urandom_range(99) < IDLE_PERCENT)) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.hue           <= hue;
      req_bus.saturation    <= sat;
      req_bus.brightness    <= val;
      req_bus.hue_undefined <= undef;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
   endtask

   // Lower valid and wait until every expected response has arrived.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      logic undef;
      gaps_on               = 1'b1;
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.hue           <= '0;
      req_bus.saturation    <= '0;
      req_bus.brightness    <= '0;
      req_bus.hue_undefined <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Undefined hue gives black whatever the other fields hold.
      send_pixel(16'hFFFF, 17'h1FFFF, 17'h1FFFF, 1'b1);
      send_pixel(16'h8000, ONE_FX, ONE_FX, 1'b1);
      // Extremes of the fields.
      send_pixel(16'd0, 17'd0, 17'd0, 1'b0);
      send_pixel(16'd0, ONE_FX, ONE_FX, 1'b0);
      send_pixel(16'hFFFF, ONE_FX, ONE_FX, 1'b0);
      send_pixel(16'd0, 17'h0FFFF, 17'h0FFFF, 1'b0);
      // Both sides of every sector boundary.
      send_pixel(16'd10922, ONE_FX, ONE_FX, 1'b0);
      send_pixel(16'd10923, ONE_FX, ONE_FX, 1'b0);
      send_pixel(16'd21845, ONE_FX, ONE_FX, 1'b0);
      send_pixel(16'd21846, ONE_FX, ONE_FX, 1'b0);
      send_pixel(16'd32767, ONE_FX, ONE_FX, 1'b0);
      send_pixel(16'd32768, ONE_FX, ONE_FX, 1'b0);
      send_pixel(16'd43690, ONE_FX, ONE_FX, 1'b0);
      send_pixel(16'd43691, ONE_FX, ONE_FX, 1'b0);
      send_pixel(16'd54613, ONE_FX, ONE_FX, 1'b0);
      send_pixel(16'd54614, ONE_FX, ONE_FX, 1'b0);
      // Gray, black by value and saturation or value above one.
      send_pixel(16'h5555, 17'd0, ONE_FX, 1'b0);
      send_pixel(16'h1234, ONE_FX, 17'd0, 1'b0);
      send_pixel(16'h2AAA, 17'h1FFFF, 17'h10001, 1'b0);
      send_pixel(16'hAAAA, 17'h10001, 17'h1FFFF, 1'b0);

      // Let the pipeline empty completely before the random part.
      drain_responses();

      // Random pixels, with a long stretch of full-rate traffic in the middle.
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         gaps_on = !(i >= 150 && i < 250);
         undef   = ($urandom_range(99) < 8);
         send_pixel(HUE_W'($urandom), random_level(), random_level(), undef);
      end
      gaps_on = 1'b1;

      drain_responses();
      repeat (NUM_STAGES + 4) @(posedge clock);

      if (fail_count == 0) begin
         $display("** hsv_to_rgb_converter: PASSED **");
      end else begin
         $display("** hsv_to_rgb_converter: FAILED **");
      end
      $finish;
   end

endmodule
